@@ sv/aat_pkg.sv @@
package aat_pkg;

   localparam int unsigned NUM_AXES   = 3;
   localparam int unsigned COORD_W    = 32;
   localparam int unsigned HALF_W     = 31;
   localparam int unsigned COEF_W     = 16;
   localparam int unsigned ROW_W      = NUM_AXES * COEF_W;
   localparam int unsigned FRAC_SHIFT = 14;

   // 16s x 32s products, and 16u x 31u magnitude products
   localparam int unsigned CPROD_W = COEF_W + COORD_W;
   localparam int unsigned HPROD_W = COEF_W + HALF_W;
   // three products plus shifted translation, with headroom
   localparam int unsigned CACC_W  = CPROD_W + 2;
   localparam int unsigned HACC_W  = HPROD_W + 2;
   // after dropping the extra fraction bits
   localparam int unsigned CRND_W  = CACC_W - FRAC_SHIFT;
   localparam int unsigned HRND_W  = HACC_W - FRAC_SHIFT;

   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = ROW_W;
   localparam int unsigned TDATA_W    = 192;

   localparam logic [ROW_W-1:0] ROW_ZERO_RST = 48'h0000_0000_4000;
   localparam logic [ROW_W-1:0] ROW_ONE_RST  = 48'h0000_4000_0000;
   localparam logic [ROW_W-1:0] ROW_TWO_RST  = 48'h4000_0000_0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROW_ZERO = 3'd0,
      CSR_ROW_ONE  = 3'd1,
      CSR_ROW_TWO  = 3'd2,
      CSR_SHIFT_X  = 3'd3,
      CSR_SHIFT_Y  = 3'd4,
      CSR_SHIFT_Z  = 3'd5
   } csr_index_type;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic        [HALF_W-1:0]  half_type;
   typedef logic        [ROW_W-1:0]   row_type;
   typedef logic signed [CRND_W-1:0]  crnd_type;
   typedef logic        [HRND_W-1:0]  hrnd_type;

   // stage load enables handed to each lane
   typedef struct packed {
      logic s1_en;
      logic s2_en;
   } lane_ctl_type;

endpackage

@@ sv/aabb_affine_transform.sv @@
// An accepted req beat reaches its rsp beat through the registered multiply, sum and saturate stages.
// Throughput: one box per cycle while rsp beats are not held; each of the three row lanes runs six
// multipliers in parallel, so the multiply stage sets the pace.
// Reset (synchronous, active high) empties the pipeline and loads the
// identity matrix with zero translation.
module aabb_affine_transform (
   input  logic                              clock,
   input  logic                              reset,
   // box beat in
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tdata, low bit up: center_x[31:0], center_y[63:32], center_z[95:64],
   // half_x[126:96], half_y[157:127], half_z[188:158], zero fill
   input  logic [aat_pkg::TDATA_W-1:0]       req_tdata,
   // transformed box beat out
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tdata, low bit up: new_center_x[31:0], new_center_y[63:32],
   // new_center_z[95:64], new_half_x[126:96], new_half_y[157:127],
   // new_half_z[188:158], zero fill
   output logic [aat_pkg::TDATA_W-1:0]       rsp_tdata,
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [aat_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [aat_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int unsigned NA = aat_pkg::NUM_AXES;
   localparam int unsigned CW = aat_pkg::COORD_W;
   localparam int unsigned HW = aat_pkg::HALF_W;

   // ---------------- matrix and translation registers ----------------
   aat_pkg::row_type   row_ff   [NA];
   aat_pkg::row_type   row_in   [NA];
   aat_pkg::coord_type shift_ff [NA];
   aat_pkg::coord_type shift_in [NA];

   // writes are always taken; codes past the last register drop
   assign csr_ready = 1'b1;

   always_comb begin
      row_in   = row_ff;
      shift_in = shift_ff;
      if (csr_valid) begin
         case (aat_pkg::csr_index_type'(csr_index))
            aat_pkg::CSR_ROW_ZERO: row_in[0]   = csr_data;
            aat_pkg::CSR_ROW_ONE:  row_in[1]   = csr_data;
            aat_pkg::CSR_ROW_TWO:  row_in[2]   = csr_data;
            aat_pkg::CSR_SHIFT_X:  shift_in[0] = csr_data[CW-1:0];
            aat_pkg::CSR_SHIFT_Y:  shift_in[1] = csr_data[CW-1:0];
            aat_pkg::CSR_SHIFT_Z:  shift_in[2] = csr_data[CW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0] <= aat_pkg::ROW_ZERO_RST;
         row_ff[1] <= aat_pkg::ROW_ONE_RST;
         row_ff[2] <= aat_pkg::ROW_TWO_RST;
         for (int i = 0; i < NA; i++) shift_ff[i] <= '0;
      end else begin
         row_ff   <= row_in;
         shift_ff <= shift_in;
      end
   end

   // ---------------- unpack the box beat ----------------
   aat_pkg::coord_type center [NA];
   aat_pkg::half_type  half   [NA];

   always_comb begin
      for (int j = 0; j < NA; j++) begin
         center[j] = req_tdata[j*CW +: CW];
         half[j]   = req_tdata[NA*CW + j*HW +: HW];
      end
   end

   // ---------------- pipeline control ----------------
   // A stage loads whenever it is empty or its contents move on, so the
   // pipe runs full rate and only stalls back from a held rsp beat.
   logic                 s1_vld_ff, s1_vld_in;
   logic                 s2_vld_ff, s2_vld_in;
   logic                 merge_ready;
   aat_pkg::lane_ctl_type ctl;

   assign ctl.s2_en  = !s2_vld_ff || merge_ready;
   assign ctl.s1_en  = !s1_vld_ff || ctl.s2_en;
   assign req_tready = ctl.s1_en;

   assign s1_vld_in = ctl.s1_en ? req_tvalid : s1_vld_ff;
   assign s2_vld_in = ctl.s2_en ? s1_vld_ff  : s2_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s2_vld_in;
      end
   end

   // ---------------- one lane per matrix row ----------------
   aat_pkg::crnd_type csum [NA];
   aat_pkg::hrnd_type hsum [NA];

   for (genvar i = 0; i < NA; i++) begin : g_lane
      aat_lane u_lane (
         .clock    (clock),
         .ctl      (ctl),
         .row_i    (row_ff[i]),
         .shift_i  (shift_ff[i]),
         .center_i (center),
         .half_i   (half),
         .csum_o   (csum[i]),
         .hsum_o   (hsum[i])
      );
   end

   // ---------------- saturate, pack, output register ----------------
   aat_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_vld_ff),
      .in_ready  (merge_ready),
      .csum_i    (csum),
      .hsum_i    (hsum),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

   // ---------------- checks ----------------
   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> s1_vld_ff)
      else $error("accepted beat did not enter stage 1");

   a_s2_moves_out: assert property (@(posedge clock) disable iff (reset)
      (s2_vld_ff && merge_ready) |=> rsp_tvalid)
      else $error("stage 2 result lost on the way to the output");

   a_empty_is_ready: assert property (@(posedge clock) disable iff (reset)
      (!s1_vld_ff && !s2_vld_ff && !rsp_tvalid) |-> req_tready)
      else $error("empty pipeline refused a beat");

   a_s1_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && !ctl.s1_en) |=> s1_vld_ff)
      else $error("stalled stage 1 beat dropped");

   a_shift_x_write: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_index == aat_pkg::CSR_SHIFT_X)
      |=> shift_ff[0] == $past(csr_data[CW-1:0]))
      else $error("shift_x write not taken");

endmodule

@@ sv/aat_lane.sv @@
// One matrix row: three products per sum in stage 1, rounded sums in stage 2.
module aat_lane (
   input  logic                  clock,
   input  aat_pkg::lane_ctl_type ctl,
   input  aat_pkg::row_type      row_i,
   input  aat_pkg::coord_type    shift_i,
   input  aat_pkg::coord_type    center_i [aat_pkg::NUM_AXES],
   input  aat_pkg::half_type     half_i   [aat_pkg::NUM_AXES],
   output aat_pkg::crnd_type     csum_o,
   output aat_pkg::hrnd_type     hsum_o
);

   localparam int unsigned NA = aat_pkg::NUM_AXES;
   localparam int unsigned CW = aat_pkg::COEF_W;

   logic signed [aat_pkg::CPROD_W-1:0] cprod_ff [NA];
   logic signed [aat_pkg::CPROD_W-1:0] cprod_in [NA];
   logic        [aat_pkg::HPROD_W-1:0] hprod_ff [NA];
   logic        [aat_pkg::HPROD_W-1:0] hprod_in [NA];
   logic signed [aat_pkg::COORD_W-1:0] shift_ff;
   aat_pkg::crnd_type                  csum_ff, csum_in;
   aat_pkg::hrnd_type                  hsum_ff, hsum_in;

   always_comb begin
      logic signed [CW-1:0] m;
      logic        [CW-1:0] am;
      for (int j = 0; j < NA; j++) begin
         m  = $signed(row_i[j*CW +: CW]);
         // magnitude; the most negative entry maps to 2^15 unsigned
         am = m[CW-1] ? CW'(~m + 1'b1) : CW'(m);
         cprod_in[j] = aat_pkg::CPROD_W'(m) * aat_pkg::CPROD_W'(center_i[j]);
         hprod_in[j] = aat_pkg::HPROD_W'(am) * aat_pkg::HPROD_W'(half_i[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.s1_en) begin
         cprod_ff <= cprod_in;
         hprod_ff <= hprod_in;
         shift_ff <= shift_i;
      end
   end

   always_comb begin
      logic signed [aat_pkg::CACC_W-1:0] cacc;
      logic        [aat_pkg::HACC_W-1:0] hacc;
      cacc = (aat_pkg::CACC_W'(shift_ff) <<< aat_pkg::FRAC_SHIFT)
             + aat_pkg::CACC_W'(signed'(1 << (aat_pkg::FRAC_SHIFT - 1)));
      hacc = aat_pkg::HACC_W'(1 << (aat_pkg::FRAC_SHIFT - 1));
      for (int j = 0; j < NA; j++) begin
         cacc = cacc + aat_pkg::CACC_W'(cprod_ff[j]);
         hacc = hacc + aat_pkg::HACC_W'(hprod_ff[j]);
      end
      // round half up: bias added above, floor by dropping fraction bits
      csum_in = cacc[aat_pkg::CACC_W-1:aat_pkg::FRAC_SHIFT];
      hsum_in = hacc[aat_pkg::HACC_W-1:aat_pkg::FRAC_SHIFT];
   end

   always_ff @(posedge clock) begin
      if (ctl.s2_en) begin
         csum_ff <= csum_in;
         hsum_ff <= hsum_in;
      end
   end

   assign csum_o = csum_ff;
   assign hsum_o = hsum_ff;

endmodule

@@ sv/aat_merge.sv @@
// Saturates the lane sums and holds the packed result beat.
module aat_merge (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  aat_pkg::crnd_type      csum_i [aat_pkg::NUM_AXES],
   input  aat_pkg::hrnd_type      hsum_i [aat_pkg::NUM_AXES],
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [aat_pkg::TDATA_W-1:0] out_data
);

   localparam int unsigned NA = aat_pkg::NUM_AXES;
   localparam int unsigned CW = aat_pkg::COORD_W;
   localparam int unsigned HW = aat_pkg::HALF_W;
   localparam int unsigned PW = NA * (CW + HW);

   logic                        vld_ff, vld_in;
   logic [aat_pkg::TDATA_W-1:0] data_ff, data_in;

   always_comb begin
      logic [PW-1:0]  packed_res;
      aat_pkg::crnd_type c;
      aat_pkg::hrnd_type h;
      packed_res = '0;
      for (int i = 0; i < NA; i++) begin
         c = csum_i[i];
         h = hsum_i[i];
         // signed overflow when the bits above the sign do not agree
         if (c[aat_pkg::CRND_W-1:CW-1] == '0 || c[aat_pkg::CRND_W-1:CW-1] == '1)
            packed_res[i*CW +: CW] = c[CW-1:0];
         else if (c[aat_pkg::CRND_W-1])
            packed_res[i*CW +: CW] = {1'b1, {(CW-1){1'b0}}};
         else
            packed_res[i*CW +: CW] = {1'b0, {(CW-1){1'b1}}};
         if (|h[aat_pkg::HRND_W-1:HW])
            packed_res[NA*CW + i*HW +: HW] = '1;
         else
            packed_res[NA*CW + i*HW +: HW] = h[HW-1:0];
      end
      data_in = aat_pkg::TDATA_W'(packed_res);
   end

   assign in_ready = !vld_ff || out_ready;
   assign vld_in   = in_ready ? in_valid : vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_data  = data_ff;

endmodule
